// ===== design/cmcps_pkg.sv =====
// Package for the committed minimum-cost path selector.
// Holds the offset tolerances, the register map and the configuration reset value.
// No dependencies.
`timescale 1ns / 1ps

package cmcps_pkg;

    localparam int unsigned COST_W   = 32;
    localparam int unsigned OFFS_W   = 16;
    localparam int unsigned POS_W    = 24;
    localparam int unsigned END_W    = 25;
    localparam int unsigned PLEN_W   = 16;
    localparam int unsigned OIDX_W   = 5;
    localparam int unsigned DIFF_W   = OFFS_W + 1;

    localparam logic [DIFF_W-1:0] MATCH_TOL = DIFF_W'(10);
    localparam logic [DIFF_W-1:0] RENEW_TOL = DIFF_W'(1000);

    localparam logic [PLEN_W-1:0] PATH_LEN_RESET = PLEN_W'(5000);

    typedef enum logic [0:0] {
        REG_COMMIT_SPAN = 1'b0
    } t_reg_idx;

endpackage

// ===== design/committed_min_cost_path_select_top.sv =====
// Top level of the committed minimum-cost path selector.
// Depends on cmcps_pkg for constants and the register map.
//
// Channel     Direction  Contents
// s_axis      in         one candidate per transfer, tlast closes the batch
// m_axis      out        one selection result per batch
// apb         in/out     commit span in millimeters at byte address 0
//
// A candidate enters the input register and then updates the running minima and
// the commit match, so one candidate is taken every cycle unless a last one waits.
// The result of a batch is registered in the output register from the input register
// holding its last candidate, through the single compare-and-select stage between
// the two registers. Reset is synchronous and clears the commit and the batch.
// Only a last candidate waits, and only while an earlier result is not taken.
`timescale 1ns / 1ps

module committed_min_cost_path_select_top
    import cmcps_pkg::*;
#(
    parameter int unsigned MAX_CANDIDATES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cost [31:0], lateral_offset [47:32], position_s [71:48]
    input  logic [71:0] s_axis_tdata,
    // collided [0], off_track [1]
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // chosen_index [4:0], chosen_offset [20:5], zero [23:21]
    output logic [23:0] m_axis_tdata,
    // no_safe_path [0], kept_commit [1], new_commit [2]
    output logic [2:0]  m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned CNT_W = $clog2(MAX_CANDIDATES + 1);
    localparam int unsigned IDX_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;

    logic [PLEN_W-1:0] r_path_len;

    logic                     r_s1_valid;
    logic signed [COST_W-1:0] r_s1_cost;
    logic signed [OFFS_W-1:0] r_s1_off;
    logic                     r_s1_unsafe;
    logic [POS_W-1:0]         r_s1_pos;
    logic                     r_s1_last;

    logic                     r_commit_valid;
    logic signed [OFFS_W-1:0] r_commit_off;
    logic [END_W-1:0]         r_commit_end;

    logic [CNT_W-1:0]         r_count;
    logic signed [COST_W-1:0] r_any_cost;
    logic [IDX_W-1:0]         r_any_idx;
    logic signed [OFFS_W-1:0] r_any_off;
    logic                     r_safe_seen;
    logic signed [COST_W-1:0] r_safe_cost;
    logic [IDX_W-1:0]         r_safe_idx;
    logic signed [OFFS_W-1:0] r_safe_off;
    logic                     r_match_seen;
    logic [IDX_W-1:0]         r_match_idx;
    logic                     r_match_safe;
    logic signed [OFFS_W-1:0] r_match_off;

    logic                     r_m_valid;
    logic [23:0]              r_m_data;
    logic [2:0]               r_m_user;

    logic                     n_commit_valid;
    logic signed [OFFS_W-1:0] n_commit_off;
    logic [END_W-1:0]         n_commit_end;
    logic [CNT_W-1:0]         n_count;
    logic signed [COST_W-1:0] n_any_cost;
    logic [IDX_W-1:0]         n_any_idx;
    logic signed [OFFS_W-1:0] n_any_off;
    logic                     n_safe_seen;
    logic signed [COST_W-1:0] n_safe_cost;
    logic [IDX_W-1:0]         n_safe_idx;
    logic signed [OFFS_W-1:0] n_safe_off;
    logic                     n_match_seen;
    logic [IDX_W-1:0]         n_match_idx;
    logic                     n_match_safe;
    logic signed [OFFS_W-1:0] n_match_off;
    logic [23:0]              n_m_data;
    logic [2:0]               n_m_user;

    logic                     s_accept;
    logic                     s1_adv;
    logic                     cfg_wr;

    logic                     in_range;
    logic [IDX_W-1:0]         cur_idx;
    logic                     any_upd;
    logic                     safe_upd;
    logic                     batch_safe;
    logic signed [DIFF_W-1:0] match_diff;
    logic [DIFF_W-1:0]        match_mag;
    logic                     match_hit;
    logic [IDX_W-1:0]         ch_idx;
    logic signed [OFFS_W-1:0] ch_off;
    logic [31:0]              ch_idx_wide;
    logic                     keep;
    logic                     drop;
    logic signed [DIFF_W-1:0] renew_diff;
    logic [DIFF_W-1:0]        renew_mag;
    logic                     renew;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (t_reg_idx'(paddr[2]))
            REG_COMMIT_SPAN: prdata = {{(32 - PLEN_W){1'b0}}, r_path_len};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_len <= PATH_LEN_RESET;
        end else if (cfg_wr && (t_reg_idx'(paddr[2]) == REG_COMMIT_SPAN)) begin
            r_path_len <= pwdata[PLEN_W-1:0];
        end
    end

    assign s1_adv        = r_s1_valid && (!r_s1_last || !r_m_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_range   = r_count < CNT_W'(MAX_CANDIDATES);
        cur_idx    = r_count[IDX_W-1:0];
        any_upd    = in_range && ((r_count == '0) || (r_s1_cost < r_any_cost));
        safe_upd   = in_range && !r_s1_unsafe && (!r_safe_seen || (r_s1_cost < r_safe_cost));
        batch_safe = r_safe_seen || safe_upd;
        match_diff = DIFF_W'(r_s1_off) - DIFF_W'(r_commit_off);
        match_mag  = match_diff[DIFF_W-1] ? DIFF_W'(-match_diff) : DIFF_W'(match_diff);
        match_hit  = in_range && r_commit_valid && !r_match_seen && (match_mag < MATCH_TOL);

        n_count      = in_range ? r_count + CNT_W'(1) : r_count;
        n_any_cost   = any_upd ? r_s1_cost : r_any_cost;
        n_any_idx    = any_upd ? cur_idx : r_any_idx;
        n_any_off    = any_upd ? r_s1_off : r_any_off;
        n_safe_seen  = batch_safe;
        n_safe_cost  = safe_upd ? r_s1_cost : r_safe_cost;
        n_safe_idx   = safe_upd ? cur_idx : r_safe_idx;
        n_safe_off   = safe_upd ? r_s1_off : r_safe_off;
        n_match_seen = r_match_seen || match_hit;
        n_match_idx  = match_hit ? cur_idx : r_match_idx;
        n_match_safe = match_hit ? !r_s1_unsafe : r_match_safe;
        n_match_off  = match_hit ? r_s1_off : r_match_off;

        keep = r_commit_valid && n_match_seen && n_match_safe
               && (END_W'(r_s1_pos) < r_commit_end);
        drop = r_commit_valid && n_match_seen && !keep;

        if (keep) begin
            ch_idx = n_match_idx;
            ch_off = n_match_off;
        end else if (batch_safe) begin
            ch_idx = n_safe_idx;
            ch_off = n_safe_off;
        end else begin
            ch_idx = n_any_idx;
            ch_off = n_any_off;
        end

        renew_diff = DIFF_W'(ch_off) - DIFF_W'(r_commit_off);
        renew_mag  = renew_diff[DIFF_W-1] ? DIFF_W'(-renew_diff) : DIFF_W'(renew_diff);
        renew      = !r_commit_valid || drop || (renew_mag > RENEW_TOL);

        n_commit_valid = r_commit_valid;
        n_commit_off   = r_commit_off;
        n_commit_end   = r_commit_end;
        if (r_s1_last) begin
            if (drop) begin
                n_commit_valid = 1'b0;
            end
            if (renew) begin
                n_commit_valid = 1'b1;
                n_commit_off   = ch_off;
                n_commit_end   = END_W'(r_s1_pos) + END_W'(r_path_len);
            end
            n_count      = '0;
            n_safe_seen  = 1'b0;
            n_match_seen = 1'b0;
        end

        ch_idx_wide = 32'(ch_idx);
        n_m_data    = {3'b000, ch_off, ch_idx_wide[OIDX_W-1:0]};
        n_m_user    = {renew, keep, !batch_safe};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_cost   <= s_axis_tdata[31:0];
            r_s1_off    <= s_axis_tdata[47:32];
            r_s1_pos    <= s_axis_tdata[71:48];
            r_s1_unsafe <= s_axis_tuser[0] || s_axis_tuser[1];
            r_s1_last   <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_commit_valid <= 1'b0;
            r_commit_off   <= '0;
            r_commit_end   <= '0;
            r_count        <= '0;
            r_safe_seen    <= 1'b0;
            r_match_seen   <= 1'b0;
        end else if (s1_adv) begin
            r_commit_valid <= n_commit_valid;
            r_commit_off   <= n_commit_off;
            r_commit_end   <= n_commit_end;
            r_count        <= n_count;
            r_safe_seen    <= n_safe_seen;
            r_match_seen   <= n_match_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_any_cost   <= n_any_cost;
            r_any_idx    <= n_any_idx;
            r_any_off    <= n_any_off;
            r_safe_cost  <= n_safe_cost;
            r_safe_idx   <= n_safe_idx;
            r_safe_off   <= n_safe_off;
            r_match_idx  <= n_match_idx;
            r_match_safe <= n_match_safe;
            r_match_off  <= n_match_off;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s1_adv && r_s1_last) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_last) begin
            r_m_data <= n_m_data;
            r_m_user <= n_m_user;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    a_keep_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[1] && m_axis_tuser[2]))
        else $error("kept and renewed commit reported together");

    a_commit_after_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_last) |=> r_commit_valid)
        else $error("commit not valid after a batch result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_CANDIDATES))
        else $error("candidate count past its bound");

    a_inner_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_s1_last) |-> s1_adv)
        else $error("inner candidate stalled");

    a_batch_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_last) |=> (r_count == '0) && !r_safe_seen && !r_match_seen)
        else $error("batch state not cleared after result");

endmodule
